// ===== hdl/jdsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_pkg
// Shared types and constants for the joystick deadzone speed mapper.
// ----------------------------------------------------------------------------
package jdsm_pkg;

    // Register map indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TILT_CENTRE     = 3'd0;
    localparam logic [2:0] REG_PAN_CENTRE      = 3'd1;
    localparam logic [2:0] REG_ZOOM_CENTRE     = 3'd2;
    localparam logic [2:0] REG_MAGNET_CENTRE   = 3'd3;
    localparam logic [2:0] REG_STICK_DEADZONE  = 3'd4;
    localparam logic [2:0] REG_ZOOM_HALFBAND   = 3'd5;
    localparam logic [2:0] REG_MAGNET_DEADZONE = 3'd6;

    // Register reset values
    localparam logic [11:0] RST_TILT_CENTRE     = 12'd1980;
    localparam logic [11:0] RST_PAN_CENTRE      = 12'd1975;
    localparam logic [11:0] RST_ZOOM_CENTRE     = 12'd1950;
    localparam logic [11:0] RST_MAGNET_CENTRE   = 12'd1292;
    localparam logic [11:0] RST_STICK_DEADZONE  = 12'd100;
    localparam logic [11:0] RST_ZOOM_HALFBAND   = 12'd200;
    localparam logic [11:0] RST_MAGNET_DEADZONE = 12'd70;

    // Axis travel limits in ADC counts
    localparam logic [11:0] STICK_LOW   = 12'd1300;
    localparam logic [11:0] STICK_HIGH  = 12'd2650;
    localparam logic [11:0] ZOOM_LOW    = 12'd1080;
    localparam logic [11:0] ZOOM_HIGH   = 12'd2950;
    localparam logic [11:0] MAGNET_LOW  = 12'd1050;
    localparam logic [11:0] MAGNET_HIGH = 12'd1600;

    // Output levels
    localparam logic [7:0]  NEUTRAL   = 8'd127;
    localparam logic [11:0] SPEED_CAP = 12'd2048;

    // Axis order through the shared divider
    localparam logic [1:0] AXIS_MAGNET = 2'd0;
    localparam logic [1:0] AXIS_TILT   = 2'd1;
    localparam logic [1:0] AXIS_PAN    = 2'd2;
    localparam logic [1:0] AXIS_ZOOM   = 2'd3;

    // Zoom owner codes
    localparam logic [1:0] OWNER_NONE   = 2'd0;
    localparam logic [1:0] OWNER_STICK  = 2'd1;
    localparam logic [1:0] OWNER_MAGNET = 2'd2;

    // Quotient bits produced by the divider
    localparam int unsigned QUO_BITS = 8;

    typedef struct packed {
        logic [11:0] tilt_centre;
        logic [11:0] pan_centre;
        logic [11:0] zoom_centre;
        logic [11:0] magnet_centre;
        logic [11:0] stick_deadzone;
        logic [11:0] zoom_halfband;
        logic [11:0] magnet_deadzone;
    } cfg_t;

    typedef struct packed {
        logic       capture;   // latch input word
        logic       load;      // set up current axis
        logic       step;      // one divider iteration
        logic       publish;   // update flags and output word
        logic [1:0] axis;      // axis being worked
    } dp_cmd_t;

    typedef struct packed {
        logic neutral;         // current axis sits in its deadzone
        logic last;            // divider on its final iteration
    } dp_status_t;

endpackage

// ===== hdl/jdsm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_regs
// APB-style configuration registers: centres and deadzones of the axes.
// ----------------------------------------------------------------------------
module jdsm_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output jdsm_pkg::cfg_t     cfg
);

    jdsm_pkg::cfg_t cfg_reg;
    jdsm_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;
    logic [11:0]    rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Write decode; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                jdsm_pkg::REG_TILT_CENTRE:     cfg_next.tilt_centre     = pwdata[11:0];
                jdsm_pkg::REG_PAN_CENTRE:      cfg_next.pan_centre      = pwdata[11:0];
                jdsm_pkg::REG_ZOOM_CENTRE:     cfg_next.zoom_centre     = pwdata[11:0];
                jdsm_pkg::REG_MAGNET_CENTRE:   cfg_next.magnet_centre   = pwdata[11:0];
                jdsm_pkg::REG_STICK_DEADZONE:  cfg_next.stick_deadzone  = pwdata[11:0];
                jdsm_pkg::REG_ZOOM_HALFBAND:   cfg_next.zoom_halfband   = pwdata[11:0];
                jdsm_pkg::REG_MAGNET_DEADZONE: cfg_next.magnet_deadzone = pwdata[11:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tilt_centre     <= jdsm_pkg::RST_TILT_CENTRE;
            cfg_reg.pan_centre      <= jdsm_pkg::RST_PAN_CENTRE;
            cfg_reg.zoom_centre     <= jdsm_pkg::RST_ZOOM_CENTRE;
            cfg_reg.magnet_centre   <= jdsm_pkg::RST_MAGNET_CENTRE;
            cfg_reg.stick_deadzone  <= jdsm_pkg::RST_STICK_DEADZONE;
            cfg_reg.zoom_halfband   <= jdsm_pkg::RST_ZOOM_HALFBAND;
            cfg_reg.magnet_deadzone <= jdsm_pkg::RST_MAGNET_DEADZONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            jdsm_pkg::REG_TILT_CENTRE:     rd_val = cfg_reg.tilt_centre;
            jdsm_pkg::REG_PAN_CENTRE:      rd_val = cfg_reg.pan_centre;
            jdsm_pkg::REG_ZOOM_CENTRE:     rd_val = cfg_reg.zoom_centre;
            jdsm_pkg::REG_MAGNET_CENTRE:   rd_val = cfg_reg.magnet_centre;
            jdsm_pkg::REG_STICK_DEADZONE:  rd_val = cfg_reg.stick_deadzone;
            jdsm_pkg::REG_ZOOM_HALFBAND:   rd_val = cfg_reg.zoom_halfband;
            jdsm_pkg::REG_MAGNET_DEADZONE: rd_val = cfg_reg.magnet_deadzone;
            default:                       rd_val = 12'd0;
        endcase
    end

    assign prdata = {20'd0, rd_val};
    assign cfg    = cfg_reg;

endmodule

// ===== hdl/jdsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_ctrl
// Sequencer: walks the four axes through the shared divider, then publishes.
// ----------------------------------------------------------------------------
module jdsm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  jdsm_pkg::dp_status_t status,
    output jdsm_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // Output slot can take a new word this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.axis       = axis_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = jdsm_pkg::AXIS_MAGNET;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (status.neutral)
                begin
                    if (axis_reg == jdsm_pkg::AXIS_ZOOM)
                        state_next = ST_FINISH;
                    else
                        axis_next = axis_reg + 2'd1;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    if (axis_reg == jdsm_pkg::AXIS_ZOOM)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= jdsm_pkg::AXIS_MAGNET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Publishing never overwrites a word still waiting
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> slot_free)
        else $error("publish while output word still held");

    // A new word starts at the first axis
    a_start_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=>
            (state_reg == ST_LOAD && axis_reg == jdsm_pkg::AXIS_MAGNET))
        else $error("item did not start at first axis");

    // Finish with an empty slot goes straight back to idle
    a_finish_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("finish stuck with empty output slot");

endmodule

// ===== hdl/jdsm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_dp
// Datapath: axis clamp and deadzone test, shared restoring divider,
// speed scaling, zoom ownership flags and output word registers.
// ----------------------------------------------------------------------------
module jdsm_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  jdsm_pkg::cfg_t       cfg,
    input  jdsm_pkg::dp_cmd_t    cmd,
    output jdsm_pkg::dp_status_t status,
    input  logic [11:0]          tilt_sample,
    input  logic [11:0]          pan_sample,
    input  logic [11:0]          zoom_sample,
    input  logic [11:0]          magnet_sample,
    input  logic [11:0]          speed_sample_a,
    input  logic [11:0]          speed_sample_b,
    input  logic [11:0]          speed_sample_c,
    input  logic [11:0]          speed_sample_d,
    output logic [7:0]           pan_speed,
    output logic [7:0]           tilt_speed,
    output logic [7:0]           zoom_speed,
    output logic [7:0]           overall_speed,
    output logic [1:0]           zoom_owner
);

    // Captured word
    logic [11:0] smp_reg [4];
    logic [13:0] speed_sum_reg;

    // Per-axis results
    logic [7:0]  res_reg [4];

    // Divider
    logic [18:0] rem_reg, rem_next;
    logic [18:0] dvs_reg;
    logic [7:0]  quo_reg, quo_next;
    logic [2:0]  cnt_reg;
    logic [7:0]  off_reg;
    logic        ge;

    // Zoom ownership
    logic        stick_act_reg, stick_act_next;
    logic        mag_act_reg, mag_act_next;

    // Output word
    logic [7:0]  pan_reg, tilt_reg, zoom_reg, speed_reg;
    logic [1:0]  owner_reg;

    // Axis prep
    logic [11:0] lo, hi, c, d, v, smp;
    logic [12:0] diff;
    logic [11:0] adiff;
    logic        neutral, below;
    logic [12:0] cpd;
    logic [11:0] base, divisor;
    logic [18:0] num;
    logic [7:0]  offset;

    // Speed
    logic [11:0] avg, avg_cap;
    logic [19:0] scaled;

    // Axis limits and settings
    always_comb
    begin
        case (cmd.axis)
            jdsm_pkg::AXIS_MAGNET:
            begin
                lo = jdsm_pkg::MAGNET_LOW;
                hi = jdsm_pkg::MAGNET_HIGH;
                c  = cfg.magnet_centre;
                d  = cfg.magnet_deadzone;
            end
            jdsm_pkg::AXIS_TILT:
            begin
                lo = jdsm_pkg::STICK_LOW;
                hi = jdsm_pkg::STICK_HIGH;
                c  = cfg.tilt_centre;
                d  = cfg.stick_deadzone;
            end
            jdsm_pkg::AXIS_PAN:
            begin
                lo = jdsm_pkg::STICK_LOW;
                hi = jdsm_pkg::STICK_HIGH;
                c  = cfg.pan_centre;
                d  = cfg.stick_deadzone;
            end
            default:
            begin
                lo = jdsm_pkg::ZOOM_LOW;
                hi = jdsm_pkg::ZOOM_HIGH;
                c  = cfg.zoom_centre;
                d  = cfg.zoom_halfband;
            end
        endcase
    end

    // Clamp, deadzone test and divider operands.
    // Outside the band the span is always positive and the numerator
    // never reaches 256 spans, so 12-bit wraparound math is exact here.
    always_comb
    begin
        smp = smp_reg[cmd.axis];
        if (smp < lo)
            v = lo;
        else if (smp > hi)
            v = hi;
        else
            v = smp;

        diff    = {1'b0, v} - {1'b0, c};
        adiff   = diff[12] ? 12'(-diff) : diff[11:0];
        neutral = (adiff <= d);
        below   = (v < c);
        cpd     = {1'b0, c} + {1'b0, d};

        if (below)
        begin
            base    = v - lo;
            divisor = c - d - lo;
            num     = {base, 7'd0} - {7'd0, base};
            offset  = 8'd0;
        end
        else
        begin
            base    = v - cpd[11:0];
            divisor = hi - cpd[11:0];
            num     = {base, 7'd0};
            offset  = jdsm_pkg::NEUTRAL;
        end
    end

    // One restoring division step
    always_comb
    begin
        ge       = (rem_reg >= dvs_reg);
        rem_next = ge ? (rem_reg - dvs_reg) : rem_reg;
        quo_next = {quo_reg[6:0], ge};
    end

    // Speed: average of four, capped, times 255 / 2048
    always_comb
    begin
        avg     = speed_sum_reg[13:2];
        avg_cap = (avg > jdsm_pkg::SPEED_CAP) ? jdsm_pkg::SPEED_CAP : avg;
        scaled  = {avg_cap, 8'd0} - {8'd0, avg_cap};
    end

    // Ownership flags: stick flag first, then magnet flag from the new stick flag
    always_comb
    begin
        stick_act_next = stick_act_reg;
        if (!mag_act_reg && res_reg[jdsm_pkg::AXIS_ZOOM] != jdsm_pkg::NEUTRAL
            && !stick_act_reg)
            stick_act_next = 1'b1;
        else if (stick_act_reg && res_reg[jdsm_pkg::AXIS_ZOOM] == jdsm_pkg::NEUTRAL)
            stick_act_next = 1'b0;

        mag_act_next = mag_act_reg;
        if (!stick_act_next && res_reg[jdsm_pkg::AXIS_MAGNET] != jdsm_pkg::NEUTRAL
            && !mag_act_reg)
            mag_act_next = 1'b1;
        else if (mag_act_reg && res_reg[jdsm_pkg::AXIS_MAGNET] == jdsm_pkg::NEUTRAL)
            mag_act_next = 1'b0;
    end

    // Input capture, divider and results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg[jdsm_pkg::AXIS_MAGNET] <= magnet_sample;
            smp_reg[jdsm_pkg::AXIS_TILT]   <= tilt_sample;
            smp_reg[jdsm_pkg::AXIS_PAN]    <= pan_sample;
            smp_reg[jdsm_pkg::AXIS_ZOOM]   <= zoom_sample;
            speed_sum_reg <= ({2'd0, speed_sample_a} + {2'd0, speed_sample_b})
                           + ({2'd0, speed_sample_c} + {2'd0, speed_sample_d});
        end

        if (cmd.load)
        begin
            rem_reg <= num;
            dvs_reg <= {divisor, 7'd0};
            quo_reg <= 8'd0;
            cnt_reg <= 3'(jdsm_pkg::QUO_BITS - 1);
            off_reg <= offset;
            if (neutral)
                res_reg[cmd.axis] <= jdsm_pkg::NEUTRAL;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            dvs_reg <= {1'b0, dvs_reg[18:1]};
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
                res_reg[cmd.axis] <= quo_next + off_reg;
        end

        if (cmd.publish)
        begin
            pan_reg   <= res_reg[jdsm_pkg::AXIS_PAN];
            tilt_reg  <= res_reg[jdsm_pkg::AXIS_TILT];
            zoom_reg  <= mag_act_next ? res_reg[jdsm_pkg::AXIS_MAGNET]
                                      : res_reg[jdsm_pkg::AXIS_ZOOM];
            speed_reg <= scaled[18:11];
            owner_reg <= mag_act_next   ? jdsm_pkg::OWNER_MAGNET :
                         stick_act_next ? jdsm_pkg::OWNER_STICK  :
                                          jdsm_pkg::OWNER_NONE;
        end
    end

    // Kept ownership flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_act_reg <= 1'b0;
            mag_act_reg   <= 1'b0;
        end
        else if (cmd.publish)
        begin
            stick_act_reg <= stick_act_next;
            mag_act_reg   <= mag_act_next;
        end
    end

    assign status.neutral = neutral;
    assign status.last    = (cnt_reg == 3'd0);

    assign pan_speed     = pan_reg;
    assign tilt_speed    = tilt_reg;
    assign zoom_speed    = zoom_reg;
    assign overall_speed = speed_reg;
    assign zoom_owner    = owner_reg;

    // Only one source owns zoom
    a_owner_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stick_act_reg && mag_act_reg))
        else $error("both zoom sources active");

    // Outside the deadzone the segment span is never zero
    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !neutral) |=> (dvs_reg != 19'd0))
        else $error("zero divisor loaded");

    // Partial remainder stays below twice the shifted divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ({1'b0, rem_reg} < {dvs_reg, 1'b0}))
        else $error("divider remainder out of range");

endmodule

// ===== hdl/joystick_deadzone_speed_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_speed_mapper_core
// Maps one word of joystick, magnetic sensor and speed-pot readings to
// pan, tilt, zoom and overall speed commands with zoom ownership.
// ----------------------------------------------------------------------------
// One input word is worked at a time. The four axes (magnet, tilt, pan, zoom)
// pass in turn through one shared restoring divider that yields one quotient
// bit per cycle: an axis inside its deadzone takes only a load step, any other
// axis a load step and then one division step per quotient bit. The finished
// word sits in an output register, so a new word is accepted while the
// previous one still waits to be taken. Configuration is written through the
// APB port at byte address 4 * index; the user must write it only while idle,
// as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module joystick_deadzone_speed_mapper_core
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input word
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] tilt_sample,
    input  logic [11:0] pan_sample,
    input  logic [11:0] zoom_sample,
    input  logic [11:0] magnet_sample,
    input  logic [11:0] speed_sample_a,
    input  logic [11:0] speed_sample_b,
    input  logic [11:0] speed_sample_c,
    input  logic [11:0] speed_sample_d,

    // output word
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pan_speed,
    output logic [7:0]  tilt_speed,
    output logic [7:0]  zoom_speed,
    output logic [7:0]  overall_speed,
    output logic [1:0]  zoom_owner
);

    jdsm_pkg::cfg_t       cfg;
    jdsm_pkg::dp_cmd_t    cmd;
    jdsm_pkg::dp_status_t status;

    // Configuration registers
    jdsm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    jdsm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    jdsm_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .tilt_sample    (tilt_sample),
        .pan_sample     (pan_sample),
        .zoom_sample    (zoom_sample),
        .magnet_sample  (magnet_sample),
        .speed_sample_a (speed_sample_a),
        .speed_sample_b (speed_sample_b),
        .speed_sample_c (speed_sample_c),
        .speed_sample_d (speed_sample_d),
        .pan_speed      (pan_speed),
        .tilt_speed     (tilt_speed),
        .zoom_speed     (zoom_speed),
        .overall_speed  (overall_speed),
        .zoom_owner     (zoom_owner)
    );

endmodule
